/* rtl/core/iie_pkg.sv */
package iie_pkg;

  localparam int PC_W    = 14;
  localparam int WORD_W  = 32;
  localparam int LEN_W   = 15;
  localparam logic [LEN_W-1:0] LEN_RESET = 15'd16384;
  localparam logic [WORD_W-1:0] FIRST_BYTE = 32'd170;

  // kind codes
  localparam logic [4:0] K_NOP    = 5'd0;
  localparam logic [4:0] K_ADD    = 5'd1;
  localparam logic [4:0] K_SUB    = 5'd2;
  localparam logic [4:0] K_MUL    = 5'd3;
  localparam logic [4:0] K_AND    = 5'd4;
  localparam logic [4:0] K_OR     = 5'd5;
  localparam logic [4:0] K_NOR    = 5'd6;
  localparam logic [4:0] K_XOR    = 5'd7;
  localparam logic [4:0] K_ADDI   = 5'd8;
  localparam logic [4:0] K_SUBI   = 5'd9;
  localparam logic [4:0] K_MULI   = 5'd10;
  localparam logic [4:0] K_ANDI   = 5'd11;
  localparam logic [4:0] K_ORI    = 5'd12;
  localparam logic [4:0] K_NORI   = 5'd13;
  localparam logic [4:0] K_XORI   = 5'd14;
  localparam logic [4:0] K_LOAD   = 5'd15;
  localparam logic [4:0] K_STORE  = 5'd16;
  localparam logic [4:0] K_BEQ    = 5'd17;
  localparam logic [4:0] K_BNE    = 5'd18;
  localparam logic [4:0] K_BGT    = 5'd19;
  localparam logic [4:0] K_BLT    = 5'd20;
  localparam logic [4:0] K_BGE    = 5'd21;
  localparam logic [4:0] K_BLE    = 5'd22;
  localparam logic [4:0] K_MISC   = 5'd23;

  localparam logic [2:0] S_JUMP   = 3'd0;
  localparam logic [2:0] S_CALL   = 3'd1;
  localparam logic [2:0] S_RET    = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_PUTC   = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_RANGE = 3'd1;
  localparam logic [2:0] ST_OVF   = 3'd2;
  localparam logic [2:0] ST_UNF   = 3'd3;
  localparam logic [2:0] ST_FIRST = 3'd4;

  typedef logic [PC_W-1:0]   pc_t;
  typedef logic [WORD_W-1:0] word_t;

endpackage

/* rtl/core/iie_instr_if.sv */
interface iie_instr_if;
  logic        valid;
  logic        ready;
  logic [4:0]  kind;
  logic [2:0]  sub_op;
  logic [4:0]  dest_reg;
  logic [4:0]  src_reg;
  logic [4:0]  third_reg;
  logic signed [31:0] immediate;
  logic signed [31:0] read_value;

  modport source (output valid, kind, sub_op, dest_reg, src_reg, third_reg, immediate,
                  read_value, input ready);
  modport sink (input valid, kind, sub_op, dest_reg, src_reg, third_reg, immediate,
                read_value, output ready);
endinterface

/* rtl/core/iie_result_if.sv */
interface iie_result_if;
  logic        valid;
  logic        ready;
  logic [13:0] next_pc;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic [2:0]  status;
  logic        halted;

  modport source (output valid, next_pc, out_valid, out_byte, status, halted, input ready);
  modport sink (input valid, next_pc, out_valid, out_byte, status, halted, output ready);
endinterface

/* rtl/core/integer_instruction_executor.sv */
// Integer instruction executor: one decoded instruction per word, one result word per
// instruction, in order. Throughput is one instruction per cycle while the output is ready.
// The accept edge reads the data memory and return stack and loads the result register,
// which presents the word in the next cycle, so a result can leave at the edge right
// after its accept edge. A result waits in the result register while the next word is
// still taken if the output is ready at that edge; a stalled output holds the input.
// Loads write their register when the result leaves and are forwarded to a dependent
// instruction right behind them; a return's target comes from the return stack read
// and is forwarded as the pc of the next instruction.
// Write program_length through cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
module integer_instruction_executor
  import iie_pkg::*;
#(
  parameter int DATA_WORDS  = 65536,
  parameter int STACK_DEPTH = 256,
  parameter int REG_COUNT_P = 32,
  parameter int PROG_WORDS  = 16384
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata,
  iie_instr_if.sink         in_ch,
  iie_result_if.source      out_ch
);

  localparam int DA_W = $clog2(DATA_WORDS);
  localparam int SA_W = $clog2(STACK_DEPTH);
  localparam int SP_W = SA_W + 1;
  localparam int RI_W = $clog2(REG_COUNT_P);

  // state
  word_t              regs_r [REG_COUNT_P];
  word_t              dmem   [DATA_WORDS];
  pc_t                rstk   [STACK_DEPTH];
  word_t              dmem_rd_r;
  pc_t                rstk_rd_r;
  logic [SP_W-1:0]    sp_r;
  pc_t                pc_r;
  logic               first_r;
  logic [LEN_W-1:0]   len_r;

  // result stage
  logic               s2_valid_r;
  logic               s2_load_r;
  logic [RI_W-1:0]    s2_dest_r;
  logic               s2_ret_r;
  pc_t                s2_npc_r;
  logic               s2_halt_r;
  logic [2:0]         s2_status_r;
  logic               s2_bval_r;
  logic [7:0]         s2_byte_r;

  logic in_fire, out_fire;
  assign out_fire     = s2_valid_r && out_ch.ready;
  assign in_ch.ready  = !s2_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;

  // effective program length
  logic [31:0] limit;
  assign limit = (32'(len_r) > 32'(PROG_WORDS)) ? 32'(PROG_WORDS) : 32'(len_r);

  // pc of the incoming word: take a return target that is still in flight
  pc_t pc_cur;
  assign pc_cur = (s2_valid_r && s2_ret_r) ? rstk_rd_r : pc_r;

  // register read with load forwarding
  logic [RI_W-1:0] ix_d, ix_s, ix_t;
  logic ok_d, ok_s, ok_t;
  word_t rd_v, rs_v, rt_v;
  assign ix_d = RI_W'(in_ch.dest_reg);
  assign ix_s = RI_W'(in_ch.src_reg);
  assign ix_t = RI_W'(in_ch.third_reg);
  assign ok_d = 32'(in_ch.dest_reg)  < 32'(REG_COUNT_P);
  assign ok_s = 32'(in_ch.src_reg)   < 32'(REG_COUNT_P);
  assign ok_t = 32'(in_ch.third_reg) < 32'(REG_COUNT_P);

  logic fwd_ok;
  assign fwd_ok = s2_valid_r && s2_load_r;

  always_comb begin
    rd_v = !ok_d ? '0 : (fwd_ok && s2_dest_r == ix_d) ? dmem_rd_r : regs_r[ix_d];
    rs_v = !ok_s ? '0 : (fwd_ok && s2_dest_r == ix_s) ? dmem_rd_r : regs_r[ix_s];
    rt_v = !ok_t ? '0 : (fwd_ok && s2_dest_r == ix_t) ? dmem_rd_r : regs_r[ix_t];
  end

  // execute
  word_t imm, opb, alu_res, addr, nxt32, pc_inc, wr_val;
  logic [4:0] alu_op;
  logic wr_en, taken, ld_go, st_go, call_go, ret_go;
  logic [2:0] status_nxt;
  logic bval_nxt, first_nxt;
  logic [SP_W-1:0] sp_nxt;
  logic [7:0] byte_nxt;
  logic signed [31:0] sa, sb;

  assign imm    = word_t'(in_ch.immediate);
  assign addr   = rs_v + imm;
  assign pc_inc = 32'(pc_cur) + 32'd1;
  assign sa     = signed'(rd_v);
  assign sb     = signed'(rs_v);

  always_comb begin
    alu_op = (in_ch.kind >= K_ADDI) ? in_ch.kind - 5'd7 : in_ch.kind;
    opb    = (in_ch.kind >= K_ADDI) ? imm : rt_v;
    case (alu_op)
      K_ADD:   alu_res = rs_v + opb;
      K_SUB:   alu_res = rs_v - opb;
      K_MUL:   alu_res = rs_v * opb;
      K_AND:   alu_res = rs_v & opb;
      K_OR:    alu_res = rs_v | opb;
      K_NOR:   alu_res = ~(rs_v | opb);
      default: alu_res = rs_v ^ opb;
    endcase
    case (in_ch.kind)
      K_BEQ:   taken = rd_v == rs_v;
      K_BNE:   taken = rd_v != rs_v;
      K_BGT:   taken = sa > sb;
      K_BLT:   taken = sa < sb;
      K_BGE:   taken = sa >= sb;
      default: taken = sa <= sb;
    endcase
  end

  always_comb begin
    wr_en      = 1'b0;
    wr_val     = alu_res;
    ld_go      = 1'b0;
    st_go      = 1'b0;
    call_go    = 1'b0;
    ret_go     = 1'b0;
    status_nxt = ST_OK;
    bval_nxt   = 1'b0;
    byte_nxt   = '0;
    first_nxt  = first_r;
    sp_nxt     = sp_r;
    nxt32      = pc_inc;
    if (in_ch.kind >= K_ADD && in_ch.kind <= K_XORI) begin
      wr_en = ok_d;
    end else if (in_ch.kind == K_LOAD || in_ch.kind == K_STORE) begin
      if (addr >= 32'(DATA_WORDS)) status_nxt = ST_RANGE;
      else if (in_ch.kind == K_LOAD) ld_go = 1'b1;
      else st_go = 1'b1;
    end else if (in_ch.kind >= K_BEQ && in_ch.kind <= K_BLE) begin
      if (taken) nxt32 = 32'(pc_cur) + imm;
    end else if (in_ch.kind == K_MISC) begin
      unique case (in_ch.sub_op)
        S_JUMP: nxt32 = imm;
        S_CALL: begin
          if (32'(sp_r) >= 32'(STACK_DEPTH)) status_nxt = ST_OVF;
          else begin
            call_go = 1'b1;
            sp_nxt  = sp_r + 1'b1;
            nxt32   = imm;
          end
        end
        S_RET: begin
          if (sp_r == '0) status_nxt = ST_UNF;
          else begin
            ret_go = 1'b1;
            sp_nxt = sp_r - 1'b1;
          end
        end
        S_READ: begin
          wr_en  = ok_d;
          wr_val = word_t'(in_ch.read_value);
        end
        S_PUTC: begin
          if (first_r) begin
            if (rd_v != FIRST_BYTE) status_nxt = ST_FIRST;
            first_nxt = 1'b0;
          end else begin
            bval_nxt = 1'b1;
            byte_nxt = rd_v[7:0];
          end
        end
        default: ;
      endcase
    end
  end

  // memories: write at accept, registered read at accept
  always_ff @(posedge clk) begin
    if (in_fire && st_go) dmem[addr[DA_W-1:0]] <= rd_v;
    if (in_fire && ld_go) dmem_rd_r <= dmem[addr[DA_W-1:0]];
  end

  logic [SA_W-1:0] sp_m1;
  assign sp_m1 = SA_W'(sp_r - 1'b1);

  always_ff @(posedge clk) begin
    if (in_fire && call_go) rstk[sp_r[SA_W-1:0]] <= pc_inc[PC_W-1:0];
    if (in_fire && ret_go) rstk_rd_r <= rstk[sp_m1];
  end

  // register file: a leaving load writes unless the newer word writes the same register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT_P; i++) regs_r[i] <= '0;
    end else begin
      if (out_fire && s2_load_r && !(in_fire && wr_en && ix_d == s2_dest_r))
        regs_r[s2_dest_r] <= dmem_rd_r;
      if (in_fire && wr_en) regs_r[ix_d] <= wr_val;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r       <= '0;
      pc_r       <= '0;
      first_r    <= 1'b1;
      len_r      <= LEN_RESET;
      s2_valid_r <= 1'b0;
    end else begin
      if (cfg_we) len_r <= cfg_wdata;
      if (in_fire) begin
        sp_r       <= sp_nxt;
        pc_r       <= nxt32[PC_W-1:0];
        first_r    <= first_nxt;
        s2_valid_r <= 1'b1;
      end else if (out_fire) begin
        s2_valid_r <= 1'b0;
        if (s2_ret_r) pc_r <= rstk_rd_r;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s2_load_r   <= ld_go && ok_d;
      s2_dest_r   <= ix_d;
      s2_ret_r    <= ret_go;
      s2_npc_r    <= nxt32[PC_W-1:0];
      s2_halt_r   <= nxt32 >= limit;
      s2_status_r <= status_nxt;
      s2_bval_r   <= bval_nxt;
      s2_byte_r   <= byte_nxt;
    end
  end

  assign out_ch.valid     = s2_valid_r;
  assign out_ch.next_pc   = s2_ret_r ? rstk_rd_r : s2_npc_r;
  assign out_ch.halted    = s2_ret_r ? (32'(rstk_rd_r) >= limit) : s2_halt_r;
  assign out_ch.status    = s2_status_r;
  assign out_ch.out_valid = s2_bval_r;
  assign out_ch.out_byte  = s2_byte_r;

`ifndef SYNTH
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sp_r) <= 32'(STACK_DEPTH)) else $error("stack pointer past depth");
  a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_bval_r |-> s2_status_r == ST_OK) else $error("byte with error status");
  a_first_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(first_r) |-> $past(in_fire) && $past(in_ch.kind) == K_MISC
      && $past(in_ch.sub_op) == S_PUTC) else $error("first byte flag dropped without put");
`endif

endmodule

/* verif/tb.sv */
module tb;
  import iie_pkg::*;

  // One instruction as the sender sees it.
  typedef struct {
    logic [4:0] kind;
    logic [2:0] sub_op;
    logic [4:0] rd;
    logic [4:0] rs;
    logic [4:0] rt;
    word_t      imm;
    word_t      rval;
  } instr_t;

  // One result word, field for field as on the result channel.
  typedef struct {
    pc_t        next_pc;
    logic       out_valid;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       halted;
  } result_t;

  localparam int DATA_WORDS  = 65536;
  localparam int STACK_DEPTH = 256;
  localparam int PROG_WORDS  = 16384;
  localparam int MAX_GAP     = 13;
  localparam int LONG_HOLD   = 300;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  iie_instr_if  in_if ();
  iie_result_if out_if ();

  integer_instruction_executor u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_if),
    .out_ch   (out_if)
  );

  // Shadow machine state, advanced once per word sent.
  word_t           regs [32];
  word_t           data_words [int];
  int              stored_addrs [$];
  pc_t             ret_addrs [STACK_DEPTH];
  int              stack_depth;
  pc_t             cur_pc;
  logic            first_byte_pending;
  logic [LEN_W-1:0] prog_len;

  result_t pending_results [$];
  int      mismatch_count;
  int      results_seen;
  int      words_sent;
  bit      no_idle;
  bit      hold_request;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Overall watchdog: far above the slowest legal run.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic word_t alu_result(logic [4:0] op, word_t a, word_t b);
    case (op)
      K_ADD:   return a + b;
      K_SUB:   return a - b;
      K_MUL:   return a * b;
      K_AND:   return a & b;
      K_OR:    return a | b;
      K_NOR:   return ~(a | b);
      default: return a ^ b;
    endcase
  endfunction

  function automatic logic branch_taken(logic [4:0] op, word_t a, word_t b);
    case (op)
      K_BEQ:   return a == b;
      K_BNE:   return a != b;
      K_BGT:   return $signed(a) > $signed(b);
      K_BLT:   return $signed(a) < $signed(b);
      K_BGE:   return $signed(a) >= $signed(b);
      default: return $signed(a) <= $signed(b);
    endcase
  endfunction

  // Execute one instruction on the shadow state and return its result.
  function automatic result_t execute_word(instr_t w);
    result_t r;
    word_t   nxt;
    word_t   addr;
    word_t   limit;
    r = '{default: '0};
    nxt = {18'd0, cur_pc} + 32'd1;
    limit = (prog_len > PROG_WORDS) ? 32'(PROG_WORDS) : {17'd0, prog_len};
    if (w.kind >= K_ADD && w.kind <= K_XOR) begin
      regs[w.rd] = alu_result(w.kind, regs[w.rs], regs[w.rt]);
    end else if (w.kind >= K_ADDI && w.kind <= K_XORI) begin
      regs[w.rd] = alu_result(w.kind - 5'd7, regs[w.rs], w.imm);
    end else if (w.kind == K_LOAD || w.kind == K_STORE) begin
      addr = regs[w.rs] + w.imm;
      if (addr >= DATA_WORDS) begin
        r.status = ST_RANGE;
      end else if (w.kind == K_LOAD) begin
        regs[w.rd] = data_words[addr];
      end else begin
        if (!data_words.exists(addr)) stored_addrs.push_back(addr);
        data_words[addr] = regs[w.rd];
      end
    end else if (w.kind >= K_BEQ && w.kind <= K_BLE) begin
      if (branch_taken(w.kind, regs[w.rd], regs[w.rs])) nxt = {18'd0, cur_pc} + w.imm;
    end else if (w.kind == K_MISC) begin
      case (w.sub_op)
        S_JUMP: nxt = w.imm;
        S_CALL: begin
          if (stack_depth >= STACK_DEPTH) begin
            r.status = ST_OVF;
          end else begin
            ret_addrs[stack_depth] = cur_pc + 14'd1;
            stack_depth++;
            nxt = w.imm;
          end
        end
        S_RET: begin
          if (stack_depth == 0) begin
            r.status = ST_UNF;
          end else begin
            stack_depth--;
            nxt = {18'd0, ret_addrs[stack_depth]};
          end
        end
        S_READ: regs[w.rd] = w.rval;
        S_PUTC: begin
          if (first_byte_pending) begin
            if (regs[w.rd] != FIRST_BYTE) r.status = ST_FIRST;
            first_byte_pending = 1'b0;
          end else begin
            r.out_valid = 1'b1;
            r.out_byte  = regs[w.rd][7:0];
          end
        end
        default: ;
      endcase
    end
    cur_pc    = nxt[PC_W-1:0];
    r.next_pc = cur_pc;
    r.halted  = (nxt >= limit);
    return r;
  endfunction

  function automatic instr_t make_word(logic [4:0] kind, logic [2:0] sub_op, logic [4:0] rd,
                                       logic [4:0] rs, logic [4:0] rt, word_t imm,
                                       word_t rval);
    instr_t w;
    w.kind = kind; w.sub_op = sub_op; w.rd = rd; w.rs = rs; w.rt = rt;
    w.imm = imm; w.rval = rval;
    return w;
  endfunction

  function automatic word_t edgy_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'd0;
      4:       return $urandom_range(0, 16);
      default: return $urandom();
    endcase
  endfunction

  // Random instruction with content shaped by the shadow state: loads hit
  // only stored words or miss the range entirely.
  function automatic instr_t random_word();
    instr_t w;
    int     pick;
    word_t  target;
    w = make_word(5'($urandom_range(1, 14)), 3'($urandom_range(0, 7)),
                  5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                  5'($urandom_range(0, 31)), edgy_value(), $urandom());
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      // undefined opcodes, handled as no-ops
      if (pick < 3) w.kind = 5'($urandom_range(24, 31));
      else begin w.kind = K_MISC; w.sub_op = 3'($urandom_range(5, 7)); end
    end else if (pick < 32) begin
      // ALU mix, kind already drawn
    end else if (pick < 42) begin
      w.kind = K_MISC; w.sub_op = S_READ; w.rval = edgy_value();
    end else if (pick < 64) begin
      w.kind = (pick < 53) ? K_STORE : K_LOAD;
      if (w.kind == K_LOAD && stored_addrs.size() > 0 && $urandom_range(0, 9) != 0)
        target = stored_addrs[$urandom_range(0, stored_addrs.size() - 1)];
      else if (w.kind == K_STORE && $urandom_range(0, 9) < 8)
        target = (pick & 1) ? $urandom_range(0, 255) : $urandom_range(0, DATA_WORDS - 1);
      else
        target = $urandom_range(DATA_WORDS, 32'hFFFF_FFFF);
      w.imm = target - regs[w.rs];
    end else if (pick < 78) begin
      w.kind = 5'($urandom_range(K_BEQ, K_BLE));
      if ($urandom_range(0, 3) == 0) w.rs = w.rd;
      w.imm = ($urandom_range(0, 15) == 0) ? $urandom() : $urandom_range(0, 40) - 20;
    end else if (pick < 84) begin
      w.kind = K_MISC; w.sub_op = S_JUMP;
      w.imm = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, PROG_WORDS - 1);
    end else if (pick < 90) begin
      w.kind = K_MISC; w.sub_op = S_CALL; w.imm = $urandom_range(0, PROG_WORDS - 1);
    end else if (pick < 95) begin
      w.kind = K_MISC; w.sub_op = S_RET;
    end else if (pick < 98) begin
      w.kind = K_MISC; w.sub_op = S_PUTC;
    end else begin
      w.kind = K_NOP;
    end
    return w;
  endfunction

  task automatic report_mismatch(string field, int expv, int gotv);
    $display("[%0t] result %0d: %s expected %0h got %0h", $time, results_seen, field,
             expv, gotv);
    mismatch_count++;
  endtask

  // Offer one word after a random gap; return at the edge that takes it.
  task automatic send_word(instr_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.kind       <= w.kind;
    in_if.sub_op     <= w.sub_op;
    in_if.dest_reg   <= w.rd;
    in_if.src_reg    <= w.rs;
    in_if.third_reg  <= w.rt;
    in_if.immediate  <= w.imm;
    in_if.read_value <= w.rval;
    pending_results.push_back(execute_word(w));
    words_sent++;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Drop valid and wait for every expected result, plus the pipeline depth.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_length(logic [LEN_W-1:0] len);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we   <= 1'b0;
    prog_len = len;
  endtask

  // Receiver: stall a random number of cycles before each word, or one long
  // stretch when asked, then take the word.
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_request) begin
        hold_request = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // Compare every word taken on the result channel with the oldest expectation.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", 0, out_if.next_pc);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_if.next_pc !== exp_r.next_pc)
          report_mismatch("next_pc", exp_r.next_pc, out_if.next_pc);
        if (out_if.out_valid !== exp_r.out_valid)
          report_mismatch("out_valid", exp_r.out_valid, out_if.out_valid);
        if (out_if.out_byte !== exp_r.out_byte)
          report_mismatch("out_byte", exp_r.out_byte, out_if.out_byte);
        if (out_if.status !== exp_r.status)
          report_mismatch("status", exp_r.status, out_if.status);
        if (out_if.halted !== exp_r.halted)
          report_mismatch("halted", exp_r.halted, out_if.halted);
      end
    end
  end

  // Directed pass: empty-stack return, first byte rule, every operation and
  // operand extremes, memory range misses on both sides, unknown opcodes.
  task automatic test_directed();
    logic [4:0] op;
    send_word(make_word(K_MISC, S_RET, 0, 0, 0, 0, 0));
    send_word(make_word(K_MISC, S_READ, 1, 0, 0, 0, 32'h0000_01AA));
    send_word(make_word(K_MISC, S_PUTC, 1, 0, 0, 0, 0));
    send_word(make_word(K_MISC, S_READ, 2, 0, 0, 0, 32'h7FFF_FFFF));
    send_word(make_word(K_MISC, S_READ, 3, 0, 0, 0, 32'h8000_0000));
    send_word(make_word(K_MISC, S_READ, 31, 0, 0, 0, 32'hFFFF_FFFF));
    for (op = K_ADD; op <= K_XOR; op++)
      send_word(make_word(op, 0, 5'(op + 3), 2, 3, 0, 0));
    for (op = K_ADDI; op <= K_XORI; op++)
      send_word(make_word(op, 0, 5'(op + 3), 31, 0, 32'h8000_0001, 0));
    send_word(make_word(K_STORE, 0, 2, 0, 0, 32'd65535, 0));
    send_word(make_word(K_LOAD, 0, 20, 0, 0, 32'd65535, 0));
    send_word(make_word(K_STORE, 0, 2, 31, 0, 0, 0));
    send_word(make_word(K_LOAD, 0, 20, 0, 0, 32'd65536, 0));
    for (op = K_BEQ; op <= K_BLE; op++)
      send_word(make_word(op, 0, 2, 3, 0, (op & 1) ? 32'd5 : 32'hFFFF_FFFD, 0));
    send_word(make_word(K_MISC, S_JUMP, 0, 0, 0, 32'd16383, 0));
    send_word(make_word(K_MISC, S_CALL, 0, 0, 0, 32'd100, 0));
    send_word(make_word(K_MISC, S_RET, 0, 0, 0, 0, 0));
    send_word(make_word(K_MISC, S_PUTC, 2, 0, 0, 0, 0));
    send_word(make_word(5'd31, 3'd7, 31, 31, 31, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(K_MISC, 3'd5, 0, 0, 0, 0, 0));
    send_word(make_word(K_NOP, 0, 0, 0, 0, 0, 0));
  endtask

  // Fill the return stack past its depth, then unwind it past empty.
  task automatic test_return_stack();
    int i;
    for (i = 0; i <= STACK_DEPTH; i++)
      send_word(make_word(K_MISC, S_CALL, 0, 0, 0, $urandom_range(0, PROG_WORDS - 1), 0));
    for (i = 0; i <= STACK_DEPTH; i++)
      send_word(make_word(K_MISC, S_RET, 0, 0, 0, 0, 0));
  endtask

  // Hold the result side for a long stretch while words keep coming.
  task automatic test_output_stall();
    hold_request = 1'b1;
    repeat (30) send_word(random_word());
  endtask

  task automatic test_random(int count, bit quiet);
    no_idle = quiet;
    repeat (count) send_word(random_word());
    no_idle = 1'b0;
  endtask

  initial begin
    foreach (regs[i]) regs[i] = '0;
    stack_depth = 0;
    cur_pc = '0;
    first_byte_pending = 1'b1;
    prog_len = LEN_RESET;
    mismatch_count = 0;
    results_seen = 0;
    words_sent = 0;
    no_idle = 1'b0;
    hold_request = 1'b0;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    in_if.valid <= 1'b0;
    in_if.kind <= '0;
    in_if.sub_op <= '0;
    in_if.dest_reg <= '0;
    in_if.src_reg <= '0;
    in_if.third_reg <= '0;
    in_if.immediate <= '0;
    in_if.read_value <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_return_stack();
    test_output_stall();
    set_length(15'd1);
    test_random(150, 1'b0);
    set_length(15'd16384);
    test_random(100, 1'b1);
    test_random(150, 1'b0);
    set_length(15'(($urandom_range(1, 1 << 14))));
    test_random(150, 1'b0);
    test_output_stall();
    set_length(15'd200);
    test_random(100, 1'b1);
    set_length(15'd16383);
    test_random(100, 1'b0);
    drain();
    repeat (10) @(posedge clk);

    $display("Sent %0d instructions and checked %0d results over six program lengths,",
             words_sent, results_seen);
    $display("with return stack overflow and underflow and long result-side stalls.");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
